>>> design/basic_keyword_tokenizer_assert.svh
// assertion macros used by the tokenizer checker
`ifndef BASIC_KEYWORD_TOKENIZER_ASSERT_SVH
`define BASIC_KEYWORD_TOKENIZER_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define BKT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define BKT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

>>> design/bkt_pkg.sv
// shared types, codes and keyword rom contents of the keyword tokenizer
package bkt_pkg;

  localparam int KW_COUNT = 107;
  localparam int KW_IW    = 7;
  localparam int KW_SLOTS = 8;
  localparam int CW       = 7;

  localparam logic [7:0] TOKEN_BASE  = 8'h80;
  localparam logic [7:0] TOKEN_DATA  = 8'h83;
  localparam logic [7:0] TOKEN_REM   = 8'hB2;
  localparam logic [7:0] TOKEN_QUERY = 8'hBA;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_LAST     = 8'h7E;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_QMARK    = 8'h3F;

  // one keyword: length and characters, first character in slot 0
  typedef struct packed {
    logic [3:0]                     len;
    logic [KW_SLOTS-1:0][CW-1:0]    chr;
  } kw_entry_t;

  // result of one keyword scan
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [3:0]       len;
    logic [KW_IW-1:0] idx;
  } scan_res_t;

  function automatic logic [CW-1:0] upcase(logic [CW-1:0] c);
    return (c >= 7'h61 && c <= 7'h7A) ? c - 7'h20 : c;
  endfunction

  // keyword text, right aligned, zero filled on the left
  function automatic logic [63:0] kw_text(logic [KW_IW-1:0] idx);
    logic [63:0] t;
    unique case (idx)
      7'd0:   t = "END";
      7'd1:   t = "FOR";
      7'd2:   t = "NEXT";
      7'd3:   t = "DATA";
      7'd4:   t = "INPUT";
      7'd5:   t = "DEL";
      7'd6:   t = "DIM";
      7'd7:   t = "READ";
      7'd8:   t = "GR";
      7'd9:   t = "TEXT";
      7'd10:  t = "PR#";
      7'd11:  t = "IN#";
      7'd12:  t = "CALL";
      7'd13:  t = "PLOT";
      7'd14:  t = "HLIN";
      7'd15:  t = "VLIN";
      7'd16:  t = "HGR2";
      7'd17:  t = "HGR";
      7'd18:  t = "HCOLOR=";
      7'd19:  t = "HPLOT";
      7'd20:  t = "DRAW";
      7'd21:  t = "XDRAW";
      7'd22:  t = "HTAB";
      7'd23:  t = "HOME";
      7'd24:  t = "ROT=";
      7'd25:  t = "SCALE=";
      7'd26:  t = "SHLOAD";
      7'd27:  t = "TRACE";
      7'd28:  t = "NOTRACE";
      7'd29:  t = "NORMAL";
      7'd30:  t = "INVERSE";
      7'd31:  t = "FLASH";
      7'd32:  t = "COLOR=";
      7'd33:  t = "POP";
      7'd34:  t = "VTAB";
      7'd35:  t = "HIMEM:";
      7'd36:  t = "LOMEM:";
      7'd37:  t = "ONERR";
      7'd38:  t = "RESUME";
      7'd39:  t = "RECALL";
      7'd40:  t = "STORE";
      7'd41:  t = "SPEED=";
      7'd42:  t = "LET";
      7'd43:  t = "GOTO";
      7'd44:  t = "RUN";
      7'd45:  t = "IF";
      7'd46:  t = "RESTORE";
      7'd47:  t = "&";
      7'd48:  t = "GOSUB";
      7'd49:  t = "RETURN";
      7'd50:  t = "REM";
      7'd51:  t = "STOP";
      7'd52:  t = "ON";
      7'd53:  t = "WAIT";
      7'd54:  t = "LOAD";
      7'd55:  t = "SAVE";
      7'd56:  t = "DEF";
      7'd57:  t = "POKE";
      7'd58:  t = "PRINT";
      7'd59:  t = "CONT";
      7'd60:  t = "LIST";
      7'd61:  t = "CLEAR";
      7'd62:  t = "GET";
      7'd63:  t = "NEW";
      7'd64:  t = "TAB(";
      7'd65:  t = "TO";
      7'd66:  t = "FN";
      7'd67:  t = "SPC(";
      7'd68:  t = "THEN";
      7'd69:  t = "AT";
      7'd70:  t = "NOT";
      7'd71:  t = "STEP";
      7'd72:  t = "+";
      7'd73:  t = "-";
      7'd74:  t = "*";
      7'd75:  t = "/";
      7'd76:  t = "^";
      7'd77:  t = "AND";
      7'd78:  t = "OR";
      7'd79:  t = ">";
      7'd80:  t = "=";
      7'd81:  t = "<";
      7'd82:  t = "SGN";
      7'd83:  t = "INT";
      7'd84:  t = "ABS";
      7'd85:  t = "USR";
      7'd86:  t = "FRE";
      7'd87:  t = "SCRN(";
      7'd88:  t = "PDL";
      7'd89:  t = "POS";
      7'd90:  t = "SQR";
      7'd91:  t = "RND";
      7'd92:  t = "LOG";
      7'd93:  t = "EXP";
      7'd94:  t = "COS";
      7'd95:  t = "SIN";
      7'd96:  t = "TAN";
      7'd97:  t = "ATN";
      7'd98:  t = "PEEK";
      7'd99:  t = "LEN";
      7'd100: t = "STR$";
      7'd101: t = "VAL";
      7'd102: t = "ASC";
      7'd103: t = "CHR$";
      7'd104: t = "LEFT$";
      7'd105: t = "RIGHT$";
      7'd106: t = "MID$";
      default: t = 64'd0;
    endcase
    return t;
  endfunction

  // rom word: count the characters, then put the first one in slot 0
  function automatic kw_entry_t kw_entry(logic [KW_IW-1:0] idx);
    logic [63:0] t;
    kw_entry_t   e;
    int          n;
    t = kw_text(idx);
    n = 0;
    for (int i = 0; i < KW_SLOTS; i++) begin
      if (t[i*8 +: 8] != 8'd0) n = n + 1;
    end
    e.len = 4'(n);
    for (int i = 0; i < KW_SLOTS; i++) begin
      if (i < n) e.chr[i] = t[(n-1-i)*8 +: CW];
      else       e.chr[i] = '0;
    end
    return e;
  endfunction

endpackage

>>> design/bkt_kw_scan.sv
// keyword rom with registered read and longest-match search over the window
module bkt_kw_scan #(
  parameter int MAX_KEYWORD_LEN = 7
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [MAX_KEYWORD_LEN*bkt_pkg::CW-1:0]  win,
  input  logic [$clog2(MAX_KEYWORD_LEN+1)-1:0]    fill,
  output bkt_pkg::scan_res_t                      res
);

  localparam logic [bkt_pkg::KW_IW-1:0] LAST_IDX = bkt_pkg::KW_IW'(bkt_pkg::KW_COUNT - 1);

  logic [bkt_pkg::KW_IW-1:0] addr_r, addr_nxt;
  logic                      issue_r, issue_nxt;
  logic                      q_vld_r, q_vld_nxt;
  logic [bkt_pkg::KW_IW-1:0] q_idx_r;
  bkt_pkg::kw_entry_t        q_r;
  logic [3:0]                best_len_r, best_len_nxt;
  logic [bkt_pkg::KW_IW-1:0] best_idx_r, best_idx_nxt;
  logic                      done_r, done_nxt;
  logic                      hit_q;

  // rom read port, one entry per cycle
  always_ff @(posedge clk) begin
    q_r     <= bkt_pkg::kw_entry(addr_r);
    q_idx_r <= addr_r;
  end

  // compare the fetched keyword against the window head
  always_comb begin
    hit_q = q_vld_r && (q_r.len > best_len_r) && (q_r.len <= 4'(fill));
    for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
      if (4'(i) < q_r.len &&
          bkt_pkg::upcase(win[i*bkt_pkg::CW +: bkt_pkg::CW]) != q_r.chr[i]) begin
        hit_q = 1'b0;
      end
    end
  end

  // address sequencing and best-match tracking
  always_comb begin
    addr_nxt     = addr_r;
    issue_nxt    = issue_r;
    q_vld_nxt    = issue_r;
    best_len_nxt = best_len_r;
    best_idx_nxt = best_idx_r;
    done_nxt     = q_vld_r && (q_idx_r == LAST_IDX);
    if (hit_q) begin
      best_len_nxt = q_r.len;
      best_idx_nxt = q_idx_r;
    end
    if (issue_r) begin
      if (addr_r == LAST_IDX) issue_nxt = 1'b0;
      else                    addr_nxt  = addr_r + 1'b1;
    end
    if (start) begin
      addr_nxt     = '0;
      issue_nxt    = 1'b1;
      best_len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      q_vld_r <= 1'b0;
      done_r  <= 1'b0;
      addr_r  <= '0;
    end else begin
      issue_r <= issue_nxt;
      q_vld_r <= q_vld_nxt;
      done_r  <= done_nxt;
      addr_r  <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_len_r <= best_len_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign res.done = done_r;
  assign res.hit  = (best_len_r != 4'd0);
  assign res.len  = best_len_r;
  assign res.idx  = best_idx_r;

endmodule

>>> design/basic_keyword_tokenizer.sv
// BASIC keyword tokenizer: one source character in, zero to seven token bytes out.
// Characters fill a lookahead window; once it holds MAX_KEYWORD_LEN characters, and at
// end of line until it is empty, one decision is taken at the window head. A decision
// inside a string, DATA or REM text, or on '?', needs no keyword search; any other
// decision walks the 107-entry keyword rom one entry per cycle. Results wait in an
// output register; a stalled output holds the next result in S_PUT, and with it the
// next character, but not the decision that makes that result.
module basic_keyword_tokenizer #(
  parameter int MAX_KEYWORD_LEN = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // src_char
  input  logic       in_tlast,   // end_of_line
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tlast,  // last_of_line
  output logic       out_tuser   // bad_char
);

  localparam int FW = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int IW = $clog2(MAX_KEYWORD_LEN);
  localparam int CW = bkt_pkg::CW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_ERR   = 3'd5;

  logic [2:0]                          st_r, st_nxt;
  logic [MAX_KEYWORD_LEN-1:0][CW-1:0]  win_r, win_nxt;
  logic [FW-1:0]                       fill_r, fill_nxt;
  logic                                quote_r, quote_nxt;
  logic                                data_r, data_nxt;
  logic                                rem_r, rem_nxt;
  logic                                err_r, err_nxt;
  logic                                eol_r, eol_nxt;
  logic [7:0]                          res_r, res_nxt;
  logic [FW-1:0]                       used_r, used_nxt;
  logic                                out_tvalid_r, out_tvalid_nxt;
  logic [7:0]                          out_byte_r, out_byte_nxt;
  logic                                out_last_r, out_last_nxt;
  logic                                out_bad_r, out_bad_nxt;
  logic                                scan_start;
  bkt_pkg::scan_res_t                  scan_res;
  logic [7:0]                          ch_in;
  logic [7:0]                          head;
  logic [7:0]                          tok;
  logic                                out_free;

  bkt_kw_scan #(
    .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .win   (win_r),
    .fill  (fill_r),
    .res   (scan_res)
  );

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

  assign ch_in    = (in_tdata == bkt_pkg::CH_TAB) ? bkt_pkg::CH_SPACE : in_tdata;
  assign head     = {1'b0, win_r[0]};
  assign tok      = bkt_pkg::TOKEN_BASE + 8'(scan_res.idx);
  assign out_free = !out_tvalid_r || out_tready;

  // sequencer: load window, take decisions, emit results
  always_comb begin
    st_nxt         = st_r;
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    quote_nxt      = quote_r;
    data_nxt       = data_r;
    rem_nxt        = rem_r;
    err_nxt        = err_r;
    eol_nxt        = eol_r;
    res_nxt        = res_r;
    used_nxt       = used_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_bad_nxt    = out_bad_r;
    scan_start     = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          eol_nxt = in_tlast;
          if (!err_r) begin
            if (ch_in < bkt_pkg::CH_SPACE || ch_in > bkt_pkg::CH_LAST) begin
              err_nxt  = 1'b1;
              fill_nxt = '0;
            end else if (fill_r < FW'(MAX_KEYWORD_LEN)) begin
              win_nxt[fill_r[IW-1:0]] = ch_in[CW-1:0];
              fill_nxt                = fill_r + 1'b1;
            end
          end
          st_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (err_r) begin
          st_nxt = eol_r ? S_ERR : S_IDLE;
        end else if (fill_r != '0 && (eol_r || fill_r >= FW'(MAX_KEYWORD_LEN))) begin
          st_nxt = S_HEAD;
        end else begin
          if (eol_r) begin
            fill_nxt  = '0;
            quote_nxt = 1'b0;
            data_nxt  = 1'b0;
            rem_nxt   = 1'b0;
          end
          st_nxt = S_IDLE;
        end
      end
      S_HEAD: begin
        used_nxt = FW'(1);
        res_nxt  = head;
        st_nxt   = S_PUT;
        if (rem_r) begin
          // rest of line copied raw
        end else if (head == bkt_pkg::CH_QUOTE) begin
          quote_nxt = !quote_r;
        end else if (data_r) begin
          if (head == bkt_pkg::CH_COLON && !quote_r) data_nxt = 1'b0;
        end else if (quote_r) begin
          // string text copied raw
        end else if (head == bkt_pkg::CH_QMARK) begin
          res_nxt = bkt_pkg::TOKEN_QUERY;
        end else begin
          scan_start = 1'b1;
          st_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            res_nxt  = tok;
            used_nxt = FW'(scan_res.len);
            if (tok == bkt_pkg::TOKEN_DATA) data_nxt = 1'b1;
            if (tok == bkt_pkg::TOKEN_REM)  rem_nxt  = 1'b1;
          end else begin
            res_nxt  = {1'b0, bkt_pkg::upcase(win_r[0])};
            used_nxt = FW'(1);
          end
          st_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_byte_nxt   = res_r;
          out_last_nxt   = eol_r && (fill_r == used_r);
          out_bad_nxt    = 1'b0;
          // drop the consumed characters from the window head
          for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
            if (i + int'(used_r) < MAX_KEYWORD_LEN) begin
              win_nxt[i] = win_r[IW'(i + int'(used_r))];
            end
          end
          fill_nxt = fill_r - used_r;
          st_nxt   = S_CHECK;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_byte_nxt   = 8'd0;
          out_last_nxt   = 1'b1;
          out_bad_nxt    = 1'b1;
          fill_nxt       = '0;
          quote_nxt      = 1'b0;
          data_nxt       = 1'b0;
          rem_nxt        = 1'b0;
          err_nxt        = 1'b0;
          st_nxt         = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      fill_r       <= '0;
      quote_r      <= 1'b0;
      data_r       <= 1'b0;
      rem_r        <= 1'b0;
      err_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      fill_r       <= fill_nxt;
      quote_r      <= quote_nxt;
      data_r       <= data_nxt;
      rem_r        <= rem_nxt;
      err_r        <= err_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // window and payload
  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    eol_r      <= eol_nxt;
    res_r      <= res_nxt;
    used_r     <= used_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

endmodule

>>> design/bkt_checker.sv
// port-level checker for the keyword tokenizer and its bind
`include "basic_keyword_tokenizer_assert.svh"

module bkt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // a stalled result holds
  `BKT_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // an error result closes the line
  `BKT_ASSERT_IMP(a_bad_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)

  // an error result carries a zero byte
  `BKT_ASSERT_IMP(a_bad_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == 8'd0)

  // the block is not ready in the cycle after a character transfer
  `BKT_ASSERT_NXT(a_in_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

bind basic_keyword_tokenizer bkt_checker u_bkt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
